@@ sv/lvcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lvcs_pkg
// shared constants and types for the 3x3 fixed-point linear solver
// ----------------------------------------------------------------------------
package lvcs_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int THR_BITS      = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

  typedef enum logic {
    ST_SOLVED   = 1'b0,
    ST_SINGULAR = 1'b1
  } status_e;

endpackage

@@ sv/lvcs_front.sv @@
// ----------------------------------------------------------------------------
// lvcs_front
// cofactors, determinant and numerators; classifies each system as solvable
// or singular and hands magnitudes and signs on to the divider
// ----------------------------------------------------------------------------
module lvcs_front import lvcs_pkg::*; #(
  parameter int W  = WORD_BITS_DEF,
  parameter int F  = FRAC_BITS_DEF,
  parameter int SW = 3 * W + 3,
  parameter int NW = SW + F
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic signed [W-1:0] a_i [3][3],
  input  logic signed [W-1:0] rhs_i [3],
  input  logic [THR_BITS-1:0] thr_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output logic                sng_o,
  output logic                dneg_o,
  output logic [SW-1:0]       dmag_o,
  output logic [2:0]          nneg_o,
  output logic [NW-1:0]       nmag_o [3]
);

  localparam int PW  = 2 * W;
  localparam int CFW = 2 * W + 1;
  localparam int PR  = 2 * W + 1;
  localparam int XW  = SW + THR_BITS + 2 * F;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv;

  logic signed [PW-1:0]  p1_q [3][3];
  logic signed [PW-1:0]  p2_q [3][3];
  logic signed [CFW-1:0] cof_q [3][3];
  logic signed [W-1:0]   a0_q1 [3];
  logic signed [W-1:0]   a0_q2 [3];
  logic signed [W-1:0]   rhs_q1 [3];
  logic signed [W-1:0]   rhs_q2 [3];
  logic signed [PR-1:0]  dlo_q [3];
  logic signed [PR-1:0]  dhi_q [3];
  logic signed [PR-1:0]  nlo_q [3][3];
  logic signed [PR-1:0]  nhi_q [3][3];
  logic signed [SW-1:0]  det_d, det_q;
  logic signed [SW-1:0]  num_d [3];
  logic signed [SW-1:0]  num_q [3];

  assign adv    = !v5_q || rdy_i;
  assign full_o = !adv;
  assign vld_o  = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // minors and cofactors, cyclic index order supplies the sign
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int K1 = (r + 1) % 3;
      localparam int K2 = (r + 2) % 3;
      localparam int L1 = (c + 1) % 3;
      localparam int L2 = (c + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          p1_q[r][c]  <= a_i[K1][L1] * a_i[K2][L2];
          p2_q[r][c]  <= a_i[K1][L2] * a_i[K2][L1];
          cof_q[r][c] <= $signed({p1_q[r][c][PW-1], p1_q[r][c]})
                       - $signed({p2_q[r][c][PW-1], p2_q[r][c]});
          // cof(c,r) * rhs(c) contributes to solution element r
          nlo_q[r][c] <= rhs_q2[c] * $signed({1'b0, cof_q[c][r][W-1:0]});
          nhi_q[r][c] <= rhs_q2[c] * $signed(cof_q[c][r][CFW-1:W]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a0_q1[r]  <= a_i[r][0];
        a0_q2[r]  <= a0_q1[r];
        rhs_q1[r] <= rhs_i[r];
        rhs_q2[r] <= rhs_q1[r];
        dlo_q[r]  <= a0_q2[r] * $signed({1'b0, cof_q[r][0][W-1:0]});
        dhi_q[r]  <= a0_q2[r] * $signed(cof_q[r][0][CFW-1:W]);
      end
    end
  end

  // recombine the split products into full-width sums
  always_comb begin
    det_d = '0;
    for (int r = 0; r < 3; r++) begin
      det_d = det_d + (SW'(dhi_q[r]) <<< W) + SW'(dlo_q[r]);
    end
    for (int i = 0; i < 3; i++) begin
      num_d[i] = '0;
      for (int c = 0; c < 3; c++) begin
        num_d[i] = num_d[i] + (SW'(nhi_q[i][c]) <<< W) + SW'(nlo_q[i][c]);
      end
    end
  end

  logic          dneg_c;
  logic [SW-1:0] dmag_c;
  logic [XW-1:0] thr_sh;

  always_comb begin
    dneg_c = det_q[SW-1];
    dmag_c = dneg_c ? SW'(-det_q) : SW'(det_q);
    thr_sh = XW'(thr_i) << (2 * F);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q  <= det_d;
      num_q  <= num_d;
      dneg_o <= dneg_c;
      dmag_o <= dmag_c;
      sng_o  <= !(XW'(dmag_c) > thr_sh);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    logic signed [NW-1:0] nx;
    always_comb begin
      nx = NW'(num_q[i]);
      nx = nx <<< F;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nneg_o[i] <= nx[NW-1];
        nmag_o[i] <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      end
    end
  end

endmodule

@@ sv/lvcs_fifo.sv @@
// ----------------------------------------------------------------------------
// lvcs_fifo
// short queue between classification and division
// ----------------------------------------------------------------------------
module lvcs_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              rdy_o,
  input  logic              rd_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              vld_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_wr, do_rd;

  assign rdy_o   = cnt_q != CNT_W'(DEPTH);
  assign vld_o   = cnt_q != '0;
  assign do_wr   = wr_i && rdy_o;
  assign do_rd   = rd_i && vld_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

@@ sv/lvcs_div.sv @@
// ----------------------------------------------------------------------------
// lvcs_div
// pipelined restoring divider, one quotient bit per stage in three lanes,
// with overflow detection, sign restore, saturation and singular zeroing
// ----------------------------------------------------------------------------
module lvcs_div import lvcs_pkg::*; #(
  parameter int W  = WORD_BITS_DEF,
  parameter int DW = 3 * W + 3,
  parameter int NW = DW + FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  output logic                rdy_o,
  input  logic                sng_i,
  input  logic                dneg_i,
  input  logic [DW-1:0]       dmag_i,
  input  logic [2:0]          nneg_i,
  input  logic [NW-1:0]       nmag_i [3],
  output logic                empty_o,
  input  logic                pop_i,
  output logic signed [W-1:0] sol_o [3],
  output logic                status_o
);

  localparam int CW = (NW > DW + W) ? NW : DW + W;
  localparam int QB = W - 1;
  localparam int NS = W - 1;

  logic          sv_q [NS+1];
  logic          sg_q [NS+1];
  logic [DW-1:0] dm_q [NS+1];
  logic [CW-1:0] rm_q [NS+1][3];
  logic [QB-1:0] qt_q [NS+1][3];
  logic          ov_q [NS+1][3];
  logic          ng_q [NS+1][3];

  logic          out_vld_q;
  status_e       st_q;
  logic          adv;

  assign adv      = !out_vld_q || pop_i;
  assign rdy_o    = adv;
  assign empty_o  = !out_vld_q;
  assign status_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) begin
        sv_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= vld_i;
      for (int s = 1; s <= NS; s++) begin
        sv_q[s] <= sv_q[s-1];
      end
      out_vld_q <= sv_q[NS];
    end
  end

  // load: quotient of 2^(W-1) or more saturates whatever its exact value
  for (genvar l = 0; l < 3; l++) begin : g_load
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rm_q[0][l] <= CW'(nmag_i[l]);
        qt_q[0][l] <= '0;
        ov_q[0][l] <= CW'(nmag_i[l]) >= (CW'(dmag_i) << QB);
        ng_q[0][l] <= nneg_i[l] ^ dneg_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sg_q[0] <= sng_i;
      dm_q[0] <= dmag_i;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int B = W - 1 - s;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sg_q[s] <= sg_q[s-1];
        dm_q[s] <= dm_q[s-1];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW-1:0] dsh;
      logic          ge;
      logic [QB-1:0] qn;
      always_comb begin
        dsh   = CW'(dm_q[s-1]) << B;
        ge    = rm_q[s-1][l] >= dsh;
        qn    = qt_q[s-1][l];
        qn[B] = ge;
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rm_q[s][l] <= ge ? rm_q[s-1][l] - dsh : rm_q[s-1][l];
          qt_q[s][l] <= qn;
          ov_q[s][l] <= ov_q[s-1][l];
          ng_q[s][l] <= ng_q[s-1][l];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [W-1:0] qz;
    logic [W-1:0] res;
    always_comb begin
      qz = W'(qt_q[NS][l]);
      if (sg_q[NS]) begin
        res = '0;
      end else if (ov_q[NS][l]) begin
        res = ng_q[NS][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res = ng_q[NS][l] ? W'(-qz) : qz;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sol_o[l] <= $signed(res);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= sg_q[NS] ? ST_SINGULAR : ST_SOLVED;
    end
  end

endmodule

@@ sv/linear_solve_3x3_cramer_core.sv @@
// ----------------------------------------------------------------------------
// linear_solve_3x3_cramer_core
// solves A*X = B for a 3x3 system in signed fixed point by cofactors
//
// channel   direction  handshake             payload
// input     in         push / full           a_r<i>c<j>_i, rhs_<i>_i
// result    out        empty / pop           sol_<i>_o, status_o
// config    in         cfg_we_i              cfg_wdata_i (det_threshold)
//
// one item enters per cycle unless full; it passes 5 front stages, the queue,
// then WORD_BITS+1 divider stages (one quotient bit per stage, three lanes).
// reset clears all valid flags and sets det_threshold to 1; no clearing pass.
// front and divider stall independently; the queue holds QUEUE_DEPTH items.
// ----------------------------------------------------------------------------
module linear_solve_3x3_cramer_core import lvcs_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [WORD_BITS-1:0] a_r1c1_i,
  input  logic signed [WORD_BITS-1:0] a_r2c1_i,
  input  logic signed [WORD_BITS-1:0] a_r3c1_i,
  input  logic signed [WORD_BITS-1:0] a_r1c2_i,
  input  logic signed [WORD_BITS-1:0] a_r2c2_i,
  input  logic signed [WORD_BITS-1:0] a_r3c2_i,
  input  logic signed [WORD_BITS-1:0] a_r1c3_i,
  input  logic signed [WORD_BITS-1:0] a_r2c3_i,
  input  logic signed [WORD_BITS-1:0] a_r3c3_i,
  input  logic signed [WORD_BITS-1:0] rhs_1_i,
  input  logic signed [WORD_BITS-1:0] rhs_2_i,
  input  logic signed [WORD_BITS-1:0] rhs_3_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [WORD_BITS-1:0] sol_1_o,
  output logic signed [WORD_BITS-1:0] sol_2_o,
  output logic signed [WORD_BITS-1:0] sol_3_o,
  output logic                        status_o,
  input  logic                        cfg_we_i,
  input  logic [THR_BITS-1:0]         cfg_wdata_i
);

  localparam int SW = 3 * WORD_BITS + 3;
  localparam int NW = SW + FRAC_BITS;
  localparam int QW = 5 + SW + 3 * NW;

  logic [THR_BITS-1:0]         thr_q;
  logic signed [WORD_BITS-1:0] a_arr [3][3];
  logic signed [WORD_BITS-1:0] rhs_arr [3];
  logic signed [WORD_BITS-1:0] sol_arr [3];

  logic          fr_vld, q_rdy, q_vld, dv_rdy;
  logic          fr_sng, fr_dneg;
  logic [SW-1:0] fr_dmag;
  logic [2:0]    fr_nneg;
  logic [NW-1:0] fr_nmag [3];
  logic [QW-1:0] q_wdata, q_rdata;
  logic          qd_sng, qd_dneg;
  logic [SW-1:0] qd_dmag;
  logic [2:0]    qd_nneg;
  logic [NW-1:0] qd_nmag [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign a_arr[0][0] = a_r1c1_i;
  assign a_arr[1][0] = a_r2c1_i;
  assign a_arr[2][0] = a_r3c1_i;
  assign a_arr[0][1] = a_r1c2_i;
  assign a_arr[1][1] = a_r2c2_i;
  assign a_arr[2][1] = a_r3c2_i;
  assign a_arr[0][2] = a_r1c3_i;
  assign a_arr[1][2] = a_r2c3_i;
  assign a_arr[2][2] = a_r3c3_i;
  assign rhs_arr[0]  = rhs_1_i;
  assign rhs_arr[1]  = rhs_2_i;
  assign rhs_arr[2]  = rhs_3_i;

  lvcs_front #(
    .W  (WORD_BITS),
    .F  (FRAC_BITS),
    .SW (SW),
    .NW (NW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .a_i    (a_arr),
    .rhs_i  (rhs_arr),
    .thr_i  (thr_q),
    .vld_o  (fr_vld),
    .rdy_i  (q_rdy),
    .sng_o  (fr_sng),
    .dneg_o (fr_dneg),
    .dmag_o (fr_dmag),
    .nneg_o (fr_nneg),
    .nmag_o (fr_nmag)
  );

  assign q_wdata = {fr_sng, fr_dneg, fr_nneg, fr_dmag,
                    fr_nmag[2], fr_nmag[1], fr_nmag[0]};

  lvcs_fifo #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_vld),
    .wdata_i (q_wdata),
    .rdy_o   (q_rdy),
    .rd_i    (dv_rdy),
    .rdata_o (q_rdata),
    .vld_o   (q_vld)
  );

  assign {qd_sng, qd_dneg, qd_nneg, qd_dmag,
          qd_nmag[2], qd_nmag[1], qd_nmag[0]} = q_rdata;

  lvcs_div #(
    .W  (WORD_BITS),
    .DW (SW),
    .NW (NW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (q_vld),
    .rdy_o    (dv_rdy),
    .sng_i    (qd_sng),
    .dneg_i   (qd_dneg),
    .dmag_i   (qd_dmag),
    .nneg_i   (qd_nneg),
    .nmag_i   (qd_nmag),
    .empty_o  (empty),
    .pop_i    (pop),
    .sol_o    (sol_arr),
    .status_o (status_o)
  );

  assign sol_1_o = sol_arr[0];
  assign sol_2_o = sol_arr[1];
  assign sol_3_o = sol_arr[2];

`ifndef SYNTHESIS
  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (sol_1_o == '0 && sol_2_o == '0 && sol_3_o == '0))
    else $error("singular result with nonzero solution");

  a_thr_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (thr_q == $past(cfg_wdata_i)))
    else $error("threshold register not updated");

  a_hold_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(sol_1_o)))
    else $error("result changed while stalled");
`endif

endmodule
